FILE: sv/ddpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddpd_pkg
// Shared widths, codes and divide-by-100 constants for the differential
// drive PD controller.
// ----------------------------------------------------------------------------
package ddpd_pkg;

    localparam int CNT_W      = 16;
    localparam int ACC_W      = 32;
    localparam int ERR_W      = 32;
    localparam int GAIN_W     = 7;
    localparam int MARGIN_W   = 16;
    localparam int SHIFT_W    = 4;
    localparam int DUTY_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int GAIN_RST   = 5;
    localparam int MARGIN_RST = 500;
    localparam int SHIFT_RST  = 2;
    localparam int GAIN_DIV   = 100;

    localparam int PIPE_STAGES = 9;

    localparam int MAG_W    = (ACC_W > ERR_W) ? ACC_W : ERR_W;
    localparam int EXT_W    = MAG_W + 1;
    localparam int P_W      = MAG_W + GAIN_W;
    localparam int REM_W    = $clog2(GAIN_DIV);
    localparam int DIV_LO_W = (P_W + 1) / 2;
    localparam int DIV_HI_W = P_W - DIV_LO_W;
    localparam int DIV_HI_S = DIV_HI_W + REM_W;
    localparam int M_HI_W   = DIV_HI_W + 1;
    localparam int QH_W     = DIV_HI_W - REM_W + 1;
    localparam int HP_W     = DIV_HI_W + M_HI_W;
    localparam int V_W      = REM_W + DIV_LO_W;
    localparam int DIV_LO_S = V_W + REM_W;
    localparam int M_LO_W   = V_W + 1;
    localparam int LP_W     = V_W + M_LO_W;
    localparam int Q_W      = QH_W + DIV_LO_W;
    localparam int SUM_W    = Q_W + 3;

    localparam longint unsigned DIV_HI_M =
        ((64'd1 << DIV_HI_S) + 64'(GAIN_DIV - 1)) / 64'(GAIN_DIV);
    localparam longint unsigned DIV_LO_M =
        ((64'd1 << DIV_LO_S) + 64'(GAIN_DIV - 1)) / 64'(GAIN_DIV);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GOAL_DIST   = 3'd0,
        CFG_GOAL_HEAD   = 3'd1,
        CFG_DIST_KP     = 3'd2,
        CFG_DIST_KD     = 3'd3,
        CFG_HEAD_KP     = 3'd4,
        CFG_MARGIN      = 3'd5,
        CFG_DUTY_SHIFT  = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        CMD_UPDATE = 1'b0,
        CMD_CHECK  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } t_dir;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_div_adv;

endpackage
`default_nettype wire

FILE: sv/ddpd_div100.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddpd_div100
// Three-stage unsigned divide by 100: reciprocal multiply on the upper half,
// remainder fold, reciprocal multiply on the lower half.
// ----------------------------------------------------------------------------
module ddpd_div100 (
    input  logic                      i_clk,
    input  ddpd_pkg::t_div_adv        i_adv,
    input  logic [ddpd_pkg::P_W-1:0]  i_mag,
    output logic [ddpd_pkg::Q_W-1:0]  o_quot
);
    import ddpd_pkg::*;

    logic [DIV_HI_W-1:0] r_uh;
    logic [DIV_LO_W-1:0] r_ul;
    logic [QH_W-1:0]     r_qh;
    logic [QH_W-1:0]     r_qh2;
    logic [V_W-1:0]      r_v;
    logic [Q_W-1:0]      r_quot;

    logic [HP_W-1:0]     n_hi_prod;
    logic [QH_W-1:0]     n_qh;
    logic [DIV_HI_W-1:0] n_rem;
    logic [V_W-1:0]      n_v;
    logic [LP_W-1:0]     n_lo_prod;
    logic [DIV_LO_W-1:0] n_ql;

    assign n_hi_prod = HP_W'(i_mag[P_W-1 -: DIV_HI_W]) * HP_W'(DIV_HI_M);
    assign n_qh      = n_hi_prod[DIV_HI_S +: QH_W];
    assign n_rem     = r_uh - (DIV_HI_W'(r_qh) * DIV_HI_W'(GAIN_DIV));
    assign n_v       = {n_rem[REM_W-1:0], r_ul};
    assign n_lo_prod = LP_W'(r_v) * LP_W'(DIV_LO_M);
    assign n_ql      = n_lo_prod[DIV_LO_S +: DIV_LO_W];

    always_ff @(posedge i_clk) begin
        if (i_adv.s1) begin
            r_uh <= i_mag[P_W-1 -: DIV_HI_W];
            r_ul <= i_mag[DIV_LO_W-1:0];
            r_qh <= n_qh;
        end
        if (i_adv.s2) begin
            r_v   <= n_v;
            r_qh2 <= r_qh;
        end
        if (i_adv.s3) begin
            r_quot <= {r_qh2, n_ql};
        end
    end

    assign o_quot = r_quot;

endmodule
`default_nettype wire

FILE: sv/differential_drive_pd_control_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// differential_drive_pd_control_top
// PD distance and P heading controller for a two-wheel drive, fed by
// encoder counter samples, with an arrival check that clears the motion state.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled; odometry
// state updates in a single stage, the gain multiplies and the three
// divide-by-100 units are fully pipelined.
// Reset (synchronous): clears the pipeline and the odometry/error state and
// loads the register defaults. No clearing pass; ready right after reset.
// ----------------------------------------------------------------------------
module differential_drive_pd_control_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_command,
    input  logic [ddpd_pkg::CNT_W-1:0]             i_left_count,
    input  logic [ddpd_pkg::CNT_W-1:0]             i_right_count,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [ddpd_pkg::DUTY_W-1:0]     o_duty_left,
    output logic signed [ddpd_pkg::DUTY_W-1:0]     o_duty_right,
    output ddpd_pkg::t_dir                         o_dir_left,
    output ddpd_pkg::t_dir                         o_dir_right,
    output logic                                   o_arrived,
    output logic signed [ddpd_pkg::ERR_W-1:0]      o_distance_error,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [ddpd_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [ddpd_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import ddpd_pkg::*;

    typedef struct packed {
        t_cmd                    cmd;
        logic                    arrived;
        logic signed [ERR_W-1:0] err;
        logic                    neg_p;
        logic                    neg_d;
        logic                    neg_h;
    } t_side;

    localparam logic signed [ERR_W-1:0]  ERR_MAX  = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0]  ERR_MIN  = {1'b1, {(ERR_W-1){1'b0}}};
    localparam logic signed [DUTY_W-1:0] DUTY_MAX = {1'b0, {(DUTY_W-1){1'b1}}};
    localparam logic signed [DUTY_W-1:0] DUTY_MIN = {1'b1, {(DUTY_W-1){1'b0}}};

    function automatic logic [MAG_W-1:0] f_mag(input logic [EXT_W-1:0] x);
        logic [EXT_W-1:0] a;
        a = x[EXT_W-1] ? (~x + 1'b1) : x;
        return a[MAG_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] f_sgn(input logic [Q_W-1:0] q, input logic neg);
        logic [SUM_W-1:0] z;
        z = SUM_W'(q);
        return neg ? (~z + 1'b1) : z;
    endfunction

    function automatic logic [DUTY_W-1:0] f_sat(input logic [SUM_W-1:0] x);
        logic ovf;
        ovf = (x[SUM_W-1:DUTY_W-1] != {(SUM_W-DUTY_W+1){x[SUM_W-1]}});
        if (ovf) begin
            return x[SUM_W-1] ? DUTY_MIN : DUTY_MAX;
        end
        return x[DUTY_W-1:0];
    endfunction

    function automatic t_dir f_dir(input logic [DUTY_W-1:0] d);
        if (d[DUTY_W-1]) begin
            return DIR_REV;
        end
        return (d == '0) ? DIR_STOP : DIR_FWD;
    endfunction

    // configuration
    logic signed [ERR_W-1:0]  r_goal_dist;
    logic signed [ERR_W-1:0]  r_goal_head;
    logic [GAIN_W-1:0]        r_kp;
    logic [GAIN_W-1:0]        r_kd;
    logic [GAIN_W-1:0]        r_kh;
    logic [MARGIN_W-1:0]      r_margin;
    logic [SHIFT_W-1:0]       r_duty_shift;

    // odometry and error state
    logic [CNT_W-1:0]         r_last_left;
    logic [CNT_W-1:0]         r_last_right;
    logic [ACC_W-1:0]         r_dist_total;
    logic [ACC_W-1:0]         r_head_total;
    logic signed [ERR_W-1:0]  r_cur_err;
    logic signed [ERR_W-1:0]  r_last_err;

    // pipeline control
    logic [PIPE_STAGES:1]     r_vld;
    logic [PIPE_STAGES:1]     rdy;

    // stage registers
    t_cmd                     r_s1_cmd;
    logic [CNT_W-1:0]         r_s1_left;
    logic [CNT_W-1:0]         r_s1_right;
    t_cmd                     r_s2_cmd;
    logic                     r_s2_arrived;
    logic signed [ERR_W-1:0]  r_s2_err;
    logic signed [ERR_W-1:0]  r_s2_last;
    logic [ACC_W-1:0]         r_s2_head;
    logic [MAG_W-1:0]         r_s3_mag_p;
    logic [MAG_W-1:0]         r_s3_mag_d;
    logic [MAG_W-1:0]         r_s3_mag_h;
    logic [P_W-1:0]           r_s4_prod_p;
    logic [P_W-1:0]           r_s4_prod_d;
    logic [P_W-1:0]           r_s4_prod_h;
    t_side                    r_side [3:8];
    logic signed [SUM_W-1:0]  r_s8_left;
    logic signed [SUM_W-1:0]  r_s8_right;
    logic signed [DUTY_W-1:0] r_duty_left;
    logic signed [DUTY_W-1:0] r_duty_right;
    t_dir                     r_dir_left;
    t_dir                     r_dir_right;
    logic                     r_arrived;
    logic signed [ERR_W-1:0]  r_dist_err;

    // stage 2 logic
    logic                     n_upd;
    logic                     n_st_en;
    logic                     n_hit;
    logic [CNT_W-1:0]         n_dl;
    logic [CNT_W-1:0]         n_dr;
    logic [CNT_W:0]           n_dsum;
    logic [CNT_W:0]           n_ddif;
    logic [ACC_W-1:0]         n_dist;
    logic [ACC_W-1:0]         n_head;
    logic [ACC_W-1:0]         n_pos_src;
    logic signed [ACC_W-1:0]  n_pos;
    logic signed [EXT_W-1:0]  n_e;
    logic signed [EXT_W-1:0]  n_marg;
    logic                     n_e_ovf;
    logic signed [ERR_W-1:0]  n_e_sat;
    logic signed [ERR_W-1:0]  n_s2_err;

    // stage 3 logic
    logic [EXT_W-1:0]         n_errx;
    logic [EXT_W-1:0]         n_derr;
    logic [EXT_W-1:0]         n_herr;
    t_side                    n_side3;

    // divider and later stages
    t_div_adv                 n_adv;
    logic [Q_W-1:0]           quot_p;
    logic [Q_W-1:0]           quot_d;
    logic [Q_W-1:0]           quot_h;
    logic [SUM_W-1:0]         n_qp;
    logic [SUM_W-1:0]         n_qd;
    logic [SUM_W-1:0]         n_qh;
    logic [SUM_W-1:0]         n_dcorr;
    logic signed [SUM_W-1:0]  n_shl;
    logic signed [SUM_W-1:0]  n_shr;
    logic [DUTY_W-1:0]        n_duty_l;
    logic [DUTY_W-1:0]        n_duty_r;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_dist  <= '0;
            r_goal_head  <= '0;
            r_kp         <= GAIN_W'(GAIN_RST);
            r_kd         <= GAIN_W'(GAIN_RST);
            r_kh         <= GAIN_W'(GAIN_RST);
            r_margin     <= MARGIN_W'(MARGIN_RST);
            r_duty_shift <= SHIFT_W'(SHIFT_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GOAL_DIST:  r_goal_dist  <= i_cfg_data[ERR_W-1:0];
                CFG_GOAL_HEAD:  r_goal_head  <= i_cfg_data[ERR_W-1:0];
                CFG_DIST_KP:    r_kp         <= i_cfg_data[GAIN_W-1:0];
                CFG_DIST_KD:    r_kd         <= i_cfg_data[GAIN_W-1:0];
                CFG_HEAD_KP:    r_kh         <= i_cfg_data[GAIN_W-1:0];
                CFG_MARGIN:     r_margin     <= i_cfg_data[MARGIN_W-1:0];
                CFG_DUTY_SHIFT: r_duty_shift <= i_cfg_data[SHIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline flow control
    // ------------------------------------------------------------------
    always_comb begin
        rdy[PIPE_STAGES] = !r_vld[PIPE_STAGES] || !i_out_stall;
        for (int k = PIPE_STAGES - 1; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= PIPE_STAGES; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_stall = !rdy[1];

    // ------------------------------------------------------------------
    // stage 1: input register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_s1_cmd   <= t_cmd'(i_command);
            r_s1_left  <= i_left_count;
            r_s1_right <= i_right_count;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: odometry, distance error, arrival check
    // ------------------------------------------------------------------
    assign n_upd   = (r_s1_cmd == CMD_UPDATE);
    assign n_st_en = r_vld[1] && rdy[2];

    assign n_dl   = r_s1_left - r_last_left;
    assign n_dr   = r_s1_right - r_last_right;
    assign n_dsum = {n_dl[CNT_W-1], n_dl} + {n_dr[CNT_W-1], n_dr};
    assign n_ddif = {n_dl[CNT_W-1], n_dl} - {n_dr[CNT_W-1], n_dr};
    assign n_dist = r_dist_total + {{(ACC_W-CNT_W-1){n_dsum[CNT_W]}}, n_dsum};
    assign n_head = r_head_total + {{(ACC_W-CNT_W-1){n_ddif[CNT_W]}}, n_ddif};

    assign n_pos_src = n_upd ? n_dist : r_dist_total;
    assign n_pos     = $signed(n_pos_src) >>> 2;
    assign n_e       = {{(EXT_W-ERR_W){r_goal_dist[ERR_W-1]}}, r_goal_dist}
                     - {{(EXT_W-ACC_W){n_pos[ACC_W-1]}}, n_pos};
    assign n_marg    = {{(EXT_W-MARGIN_W){1'b0}}, r_margin};
    assign n_e_ovf   = (n_e[EXT_W-1:ERR_W-1] != {(EXT_W-ERR_W+1){n_e[EXT_W-1]}});
    assign n_e_sat   = n_e_ovf ? (n_e[EXT_W-1] ? ERR_MIN : ERR_MAX) : n_e[ERR_W-1:0];
    assign n_hit     = !n_upd && (n_e <= n_marg) && (n_e >= -n_marg);
    assign n_s2_err  = n_upd ? n_e_sat : (n_hit ? '0 : r_cur_err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_left  <= '0;
            r_last_right <= '0;
            r_dist_total <= '0;
            r_head_total <= '0;
            r_cur_err    <= '0;
            r_last_err   <= '0;
        end else if (n_st_en) begin
            if (n_upd) begin
                r_last_left  <= r_s1_left;
                r_last_right <= r_s1_right;
                r_dist_total <= n_dist;
                r_head_total <= n_head;
                r_last_err   <= r_cur_err;
                r_cur_err    <= n_e_sat;
            end else if (n_hit) begin
                r_last_left  <= '0;
                r_last_right <= '0;
                r_dist_total <= '0;
                r_last_err   <= '0;
                r_cur_err    <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_s2_cmd     <= r_s1_cmd;
            r_s2_arrived <= n_hit;
            r_s2_err     <= n_s2_err;
            r_s2_last    <= r_cur_err;
            r_s2_head    <= n_head;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: error terms and magnitudes
    // ------------------------------------------------------------------
    assign n_errx = {{(EXT_W-ERR_W){r_s2_err[ERR_W-1]}}, r_s2_err};
    assign n_derr = n_errx - {{(EXT_W-ERR_W){r_s2_last[ERR_W-1]}}, r_s2_last};
    assign n_herr = {{(EXT_W-ERR_W){r_goal_head[ERR_W-1]}}, r_goal_head}
                  - {{(EXT_W-ACC_W){r_s2_head[ACC_W-1]}}, r_s2_head};

    always_comb begin
        n_side3.cmd     = r_s2_cmd;
        n_side3.arrived = r_s2_arrived;
        n_side3.err     = r_s2_err;
        n_side3.neg_p   = n_errx[EXT_W-1];
        n_side3.neg_d   = n_derr[EXT_W-1];
        n_side3.neg_h   = n_herr[EXT_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_s3_mag_p <= f_mag(n_errx);
            r_s3_mag_d <= f_mag(n_derr);
            r_s3_mag_h <= f_mag(n_herr);
            r_side[3]  <= n_side3;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: gain products
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r_s4_prod_p <= P_W'(r_kp) * P_W'(r_s3_mag_p);
            r_s4_prod_d <= P_W'(r_kd) * P_W'(r_s3_mag_d);
            r_s4_prod_h <= P_W'(r_kh) * P_W'(r_s3_mag_h);
            r_side[4]   <= r_side[3];
        end
    end

    // ------------------------------------------------------------------
    // stages 5 to 7: divide by 100
    // ------------------------------------------------------------------
    always_comb begin
        n_adv.s1 = rdy[5];
        n_adv.s2 = rdy[6];
        n_adv.s3 = rdy[7];
    end

    ddpd_div100 u_div_p (
        .i_clk  (i_clk),
        .i_adv  (n_adv),
        .i_mag  (r_s4_prod_p),
        .o_quot (quot_p)
    );

    ddpd_div100 u_div_d (
        .i_clk  (i_clk),
        .i_adv  (n_adv),
        .i_mag  (r_s4_prod_d),
        .o_quot (quot_d)
    );

    ddpd_div100 u_div_h (
        .i_clk  (i_clk),
        .i_adv  (n_adv),
        .i_mag  (r_s4_prod_h),
        .o_quot (quot_h)
    );

    always_ff @(posedge i_clk) begin
        for (int k = 5; k <= 7; k++) begin
            if (rdy[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 8: signed corrections and mixing
    // ------------------------------------------------------------------
    assign n_qp    = f_sgn(quot_p, r_side[7].neg_p);
    assign n_qd    = f_sgn(quot_d, r_side[7].neg_d);
    assign n_qh    = f_sgn(quot_h, r_side[7].neg_h);
    assign n_dcorr = n_qp + n_qd;

    always_ff @(posedge i_clk) begin
        if (rdy[8]) begin
            r_s8_left  <= n_dcorr + n_qh;
            r_s8_right <= n_dcorr - n_qh;
            r_side[8]  <= r_side[7];
        end
    end

    // ------------------------------------------------------------------
    // output register: scale, saturate, direction
    // ------------------------------------------------------------------
    assign n_shl    = r_s8_left >>> r_duty_shift;
    assign n_shr    = r_s8_right >>> r_duty_shift;
    assign n_duty_l = (r_side[8].cmd == CMD_CHECK) ? '0 : f_sat(n_shl);
    assign n_duty_r = (r_side[8].cmd == CMD_CHECK) ? '0 : f_sat(n_shr);

    always_ff @(posedge i_clk) begin
        if (rdy[PIPE_STAGES]) begin
            r_duty_left  <= n_duty_l;
            r_duty_right <= n_duty_r;
            r_dir_left   <= f_dir(n_duty_l);
            r_dir_right  <= f_dir(n_duty_r);
            r_arrived    <= r_side[8].arrived;
            r_dist_err   <= r_side[8].err;
        end
    end

    assign o_out_valid      = r_vld[PIPE_STAGES];
    assign o_duty_left      = r_duty_left;
    assign o_duty_right     = r_duty_right;
    assign o_dir_left       = r_dir_left;
    assign o_dir_right      = r_dir_right;
    assign o_arrived        = r_arrived;
    assign o_distance_error = r_dist_err;

`ifndef NO_ASSERTIONS
    a_arrive_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_st_en && n_hit |=> r_dist_total == '0 && r_cur_err == '0
                             && r_last_left == '0 && r_last_right == '0)
        else $error("arrival did not clear motion state");

    a_arrive_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_arrived |-> o_distance_error == '0
                                     && o_duty_left == '0 && o_duty_right == '0)
        else $error("arrival result carries nonzero error or duty");

    a_dir_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_dir_left == DIR_FWD) == (o_duty_left > 0))
                        && ((o_dir_left == DIR_REV) == (o_duty_left < 0)))
        else $error("left direction does not follow duty");

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[PIPE_STAGES] |-> !o_in_stall)
        else $error("input stalled while output register empty");
`endif

endmodule
`default_nettype wire
